// ----- sv/bba_pkg.sv -----
// Package for the buddy address allocator: sizes, status codes and the
// free-list ring address helpers. No dependencies.
`default_nettype none
package bba_pkg;
    localparam int MinOrder   = 12;
    localparam int MaxOrder   = 20;
    localparam int TopBlocks  = 4;
    localparam int NLists     = MaxOrder - MinOrder + 1;
    localparam int LvlW       = 4;
    localparam int OffW       = 22;
    localparam int OrdW       = 6;
    localparam int ValW       = OffW - MinOrder;
    localparam int ScrDepth   = TopBlocks << (MaxOrder - MinOrder);
    localparam int ScrAW      = $clog2(ScrDepth);
    localparam int CntW       = ScrAW + 1;
    localparam int StoreDepth = TopBlocks * ((2 << (MaxOrder - MinOrder)) - 1);
    localparam int AddrW      = $clog2(StoreDepth);

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_ORDER = 3'd1;
    localparam logic [2:0] ST_MISALIGN  = 3'd2;
    localparam logic [2:0] ST_EXHAUST   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // ring capacity of one level
    function automatic logic [CntW-1:0] f_cap(input logic [LvlW-1:0] lvl);
        f_cap = CntW'(ScrDepth) >> lvl;
    endfunction

    // store address of ring slot ptr (wrapped) in a level's region
    function automatic logic [AddrW-1:0] f_addr(input logic [LvlW-1:0] lvl,
                                                input logic [CntW-1:0] ptr);
        logic [CntW:0]    base;
        logic [CntW-1:0]  slot;
        base = (CntW+1)'(2 * ScrDepth) - ((CntW+1)'(2 * ScrDepth) >> lvl);
        slot = ptr & (f_cap(lvl) - CntW'(1));
        f_addr = AddrW'(base) + AddrW'(slot);
    endfunction
endpackage
`default_nettype wire

// ----- sv/bba_ram.sv -----
// Simple dual-port memory with registered read data.
// Used for the free-block store and the merge scratch list; no dependencies.
`default_nettype none
module bba_ram #(
    parameter int Width = 10,
    parameter int Depth = 1024,
    parameter int AW    = $clog2(Depth)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [Width-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic [Width-1:0]   o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ----- sv/buddy_address_allocator_top.sv -----
// Buddy address allocator top level: sequencer, free-list heads and counts.
// Depends on bba_pkg and bba_ram.
//
// Usage: one request enters on the s_axis channel (tuser = operation, 0
// allocate, 1 give back; tdata = order and byte offset). Exactly one result
// leaves on m_axis (granted offset and status). One request is worked at a
// time; s_axis tready is low from acceptance until the result transfer.
// A bad order or a give back shows its result the cycle after the request
// transfer; an allocation from a non-empty list passes S_POP and S_POP2
// before the result. Each split level passes S_SPLIT, S_SPLIT_RD and
// S_SPLIT_W2. When no larger block is free a merge pass runs over each
// smaller level: it copies the list to scratch, searches scratch for the
// buddy of each entry, and rebuilds the list. All of it goes through the
// single read port of the store and the scratch memory.
// After reset, the init state loads the top blocks into the top list;
// tready is low meanwhile. A stalled receiver holds the result on m_axis
// and the block takes no new request until that result is transferred.
`default_nettype none
module buddy_address_allocator_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,  // block_order[5:0], block_offset[27:6]
    input  wire logic        i_s_axis_tuser,  // func
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata   // granted_offset[21:0], status[24:22]
);
    localparam int LvlW  = bba_pkg::LvlW;
    localparam int CntW  = bba_pkg::CntW;
    localparam int ValW  = bba_pkg::ValW;
    localparam int AddrW = bba_pkg::AddrW;
    localparam int ScrAW = bba_pkg::ScrAW;
    localparam int NL    = bba_pkg::NLists;
    localparam logic [LvlW-1:0] TopLvl = LvlW'(NL - 1);

    localparam logic [4:0] S_INIT     = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_SPLIT    = 5'd2;
    localparam logic [4:0] S_SPLIT_RD = 5'd3;
    localparam logic [4:0] S_SPLIT_W2 = 5'd4;
    localparam logic [4:0] S_M_START  = 5'd5;
    localparam logic [4:0] S_M_CRD    = 5'd6;
    localparam logic [4:0] S_M_CWR    = 5'd7;
    localparam logic [4:0] S_M_IRD    = 5'd8;
    localparam logic [4:0] S_M_ICHK   = 5'd9;
    localparam logic [4:0] S_M_JRD    = 5'd10;
    localparam logic [4:0] S_M_JCHK   = 5'd11;
    localparam logic [4:0] S_M_GI     = 5'd12;
    localparam logic [4:0] S_M_GJ     = 5'd13;
    localparam logic [4:0] S_M_RRD    = 5'd14;
    localparam logic [4:0] S_M_RCHK   = 5'd15;
    localparam logic [4:0] S_M_NEXT   = 5'd16;
    localparam logic [4:0] S_POP      = 5'd17;
    localparam logic [4:0] S_POP2     = 5'd18;
    localparam logic [4:0] S_OUT      = 5'd19;

    logic [4:0]      r_state, n_state;
    logic [CntW-1:0] r_head [NL];
    logic [CntW-1:0] n_head [NL];
    logic [CntW-1:0] r_count [NL];
    logic [CntW-1:0] n_count [NL];
    logic [LvlW-1:0] r_lvl, n_lvl, r_d, n_d;
    logic [CntW-1:0] r_n, n_n, r_i, n_i, r_j, n_j, r_k, n_k;
    logic [ValW-1:0] r_vi, n_vi, r_want, n_want;
    logic [bba_pkg::OffW-1:0] r_granted, n_granted;
    logic [2:0]      r_status, n_status;

    logic             st_we, st_re;
    logic [AddrW-1:0] st_waddr, st_raddr;
    logic [ValW-1:0]  st_wdata, st_rdata;
    logic             sc_we, sc_re;
    logic [ScrAW-1:0] sc_waddr, sc_raddr;
    logic [ValW:0]    sc_wdata, sc_rdata;

    logic [bba_pkg::OrdW-1:0] in_ord;
    logic [bba_pkg::OffW-1:0] in_off, align_mask;
    logic [LvlW-1:0] in_lvl, dm, dn, cfound;
    logic            found, bad_ord;

    bba_ram #(.Width(ValW), .Depth(bba_pkg::StoreDepth), .AW(AddrW)) u_store (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_re(st_re), .i_raddr(st_raddr), .o_rdata(st_rdata)
    );

    bba_ram #(.Width(ValW + 1), .Depth(bba_pkg::ScrDepth), .AW(ScrAW)) u_scratch (
        .i_clk(i_clk), .i_we(sc_we), .i_waddr(sc_waddr), .i_wdata(sc_wdata),
        .i_re(sc_re), .i_raddr(sc_raddr), .o_rdata(sc_rdata)
    );

    // decode the request
    assign in_ord     = i_s_axis_tdata[5:0];
    assign in_off     = i_s_axis_tdata[27:6];
    assign in_lvl     = LvlW'(in_ord - bba_pkg::OrdW'(bba_pkg::MinOrder));
    assign bad_ord    = (in_ord < bba_pkg::OrdW'(bba_pkg::MinOrder)) ||
                        (in_ord > bba_pkg::OrdW'(bba_pkg::MaxOrder));
    assign align_mask = (bba_pkg::OffW'(1) << in_ord) - bba_pkg::OffW'(1);
    assign dm         = r_d - LvlW'(1);
    assign dn         = r_d + LvlW'(1);

    // find the smallest non-empty level above the request
    always_comb begin
        found  = 1'b0;
        cfound = '0;
        for (int m = NL - 1; m >= 0; m--) begin
            if (LvlW'(m) > in_lvl && r_count[m] != '0) begin
                found  = 1'b1;
                cfound = LvlW'(m);
            end
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state; n_head = r_head; n_count = r_count;
        n_lvl = r_lvl; n_d = r_d; n_n = r_n; n_i = r_i; n_j = r_j; n_k = r_k;
        n_vi = r_vi; n_want = r_want; n_granted = r_granted; n_status = r_status;
        st_we = 1'b0; st_re = 1'b0; st_waddr = '0; st_raddr = '0; st_wdata = '0;
        sc_we = 1'b0; sc_re = 1'b0; sc_waddr = '0; sc_raddr = '0; sc_wdata = '0;
        unique case (r_state)
            S_INIT: begin
                st_we    = 1'b1;
                st_waddr = bba_pkg::f_addr(TopLvl, r_k);
                st_wdata = ValW'(r_k) << (NL - 1);
                n_k      = r_k + CntW'(1);
                if (r_k == CntW'(bba_pkg::TopBlocks - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_granted = '0;
                    n_status  = bba_pkg::ST_OK;
                    n_lvl     = in_lvl;
                    n_state   = S_OUT;
                    if (bad_ord) begin
                        n_status = bba_pkg::ST_BAD_ORDER;
                    end else if (i_s_axis_tuser) begin
                        if ((in_off & align_mask) != '0) begin
                            n_status = bba_pkg::ST_MISALIGN;
                        end else if (r_count[in_lvl] >= bba_pkg::f_cap(in_lvl)) begin
                            n_status = bba_pkg::ST_FULL;
                        end else begin
                            st_we    = 1'b1;
                            st_waddr = bba_pkg::f_addr(in_lvl,
                                                       r_head[in_lvl] + r_count[in_lvl]);
                            st_wdata = in_off[bba_pkg::OffW-1:bba_pkg::MinOrder];
                            n_count[in_lvl] = r_count[in_lvl] + CntW'(1);
                        end
                    end else if (r_count[in_lvl] != '0) begin
                        n_state = S_POP;
                    end else if (found) begin
                        n_d     = cfound;
                        n_state = S_SPLIT;
                    end else if (in_lvl == '0) begin
                        n_status = bba_pkg::ST_EXHAUST;
                    end else begin
                        n_d     = '0;
                        n_state = S_M_START;
                    end
                end
            end
            S_SPLIT: begin
                if (bba_pkg::f_cap(dm) - r_count[dm] < CntW'(2)) begin
                    n_status = bba_pkg::ST_FULL;
                    n_state  = S_OUT;
                end else begin
                    st_re    = 1'b1;
                    st_raddr = bba_pkg::f_addr(r_d, r_head[r_d]);
                    n_state  = S_SPLIT_RD;
                end
            end
            S_SPLIT_RD: begin
                n_head[r_d]  = (r_head[r_d] + CntW'(1)) &
                               (bba_pkg::f_cap(r_d) - CntW'(1));
                n_count[r_d] = r_count[r_d] - CntW'(1);
                st_we        = 1'b1;
                st_waddr     = bba_pkg::f_addr(dm, r_head[dm] + r_count[dm]);
                st_wdata     = st_rdata;
                n_count[dm]  = r_count[dm] + CntW'(1);
                n_vi         = st_rdata;
                n_state      = S_SPLIT_W2;
            end
            S_SPLIT_W2: begin
                st_we       = 1'b1;
                st_waddr    = bba_pkg::f_addr(dm, r_head[dm] + r_count[dm]);
                st_wdata    = r_vi ^ (ValW'(1) << dm);
                n_count[dm] = r_count[dm] + CntW'(1);
                n_d         = dm;
                n_state     = (dm == r_lvl) ? S_POP : S_SPLIT;
            end
            S_M_START: begin
                n_n     = r_count[r_d];
                n_k     = '0;
                n_state = S_M_CRD;
            end
            S_M_CRD: begin
                if (r_k == r_n) begin
                    n_i     = '0;
                    n_state = S_M_IRD;
                end else begin
                    st_re    = 1'b1;
                    st_raddr = bba_pkg::f_addr(r_d, r_head[r_d] + r_k);
                    n_state  = S_M_CWR;
                end
            end
            S_M_CWR: begin
                sc_we    = 1'b1;
                sc_waddr = r_k[ScrAW-1:0];
                sc_wdata = {1'b0, st_rdata};
                n_k      = r_k + CntW'(1);
                n_state  = S_M_CRD;
            end
            S_M_IRD: begin
                if (r_i == r_n) begin
                    n_head[r_d]  = '0;
                    n_count[r_d] = '0;
                    n_k          = '0;
                    n_state      = S_M_RRD;
                end else begin
                    sc_re    = 1'b1;
                    sc_raddr = r_i[ScrAW-1:0];
                    n_state  = S_M_ICHK;
                end
            end
            S_M_ICHK: begin
                if (sc_rdata[ValW]) begin
                    n_i     = r_i + CntW'(1);
                    n_state = S_M_IRD;
                end else begin
                    n_vi    = sc_rdata[ValW-1:0];
                    n_want  = sc_rdata[ValW-1:0] ^ (ValW'(1) << r_d);
                    n_j     = '0;
                    n_state = S_M_JRD;
                end
            end
            S_M_JRD: begin
                if (r_j == r_n) begin
                    n_i     = r_i + CntW'(1);
                    n_state = S_M_IRD;
                end else begin
                    sc_re    = 1'b1;
                    sc_raddr = r_j[ScrAW-1:0];
                    n_state  = S_M_JCHK;
                end
            end
            S_M_JCHK: begin
                if (!sc_rdata[ValW] && sc_rdata[ValW-1:0] == r_want) begin
                    if (r_count[dn] >= bba_pkg::f_cap(dn)) begin
                        n_i     = r_i + CntW'(1);
                        n_state = S_M_IRD;
                    end else begin
                        n_state = S_M_GI;
                    end
                end else begin
                    n_j     = r_j + CntW'(1);
                    n_state = S_M_JRD;
                end
            end
            S_M_GI: begin
                sc_we       = 1'b1;
                sc_waddr    = r_i[ScrAW-1:0];
                sc_wdata    = {1'b1, r_vi};
                st_we       = 1'b1;
                st_waddr    = bba_pkg::f_addr(dn, r_head[dn] + r_count[dn]);
                st_wdata    = (r_vi < r_want) ? r_vi : r_want;
                n_count[dn] = r_count[dn] + CntW'(1);
                n_state     = S_M_GJ;
            end
            S_M_GJ: begin
                sc_we    = 1'b1;
                sc_waddr = r_j[ScrAW-1:0];
                sc_wdata = {1'b1, r_want};
                n_i      = r_i + CntW'(1);
                n_state  = S_M_IRD;
            end
            S_M_RRD: begin
                if (r_k == r_n) begin
                    n_state = S_M_NEXT;
                end else begin
                    sc_re    = 1'b1;
                    sc_raddr = r_k[ScrAW-1:0];
                    n_state  = S_M_RCHK;
                end
            end
            S_M_RCHK: begin
                if (!sc_rdata[ValW]) begin
                    st_we        = 1'b1;
                    st_waddr     = bba_pkg::f_addr(r_d, r_count[r_d]);
                    st_wdata     = sc_rdata[ValW-1:0];
                    n_count[r_d] = r_count[r_d] + CntW'(1);
                end
                n_k     = r_k + CntW'(1);
                n_state = S_M_RRD;
            end
            S_M_NEXT: begin
                if (dn == r_lvl) begin
                    if (r_count[r_lvl] == '0) begin
                        n_status = bba_pkg::ST_EXHAUST;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_POP;
                    end
                end else begin
                    n_d     = dn;
                    n_state = S_M_START;
                end
            end
            S_POP: begin
                st_re    = 1'b1;
                st_raddr = bba_pkg::f_addr(r_lvl, r_head[r_lvl]);
                n_state  = S_POP2;
            end
            S_POP2: begin
                n_granted      = {st_rdata, bba_pkg::MinOrder'(0)};
                n_head[r_lvl]  = (r_head[r_lvl] + CntW'(1)) &
                                 (bba_pkg::f_cap(r_lvl) - CntW'(1));
                n_count[r_lvl] = r_count[r_lvl] - CntW'(1);
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_k     <= '0;
            for (int m = 0; m < NL; m++) begin
                r_head[m]  <= '0;
                r_count[m] <= (m == NL - 1) ? CntW'(bba_pkg::TopBlocks) : '0;
            end
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_lvl     <= n_lvl;
        r_d       <= n_d;
        r_n       <= n_n;
        r_i       <= n_i;
        r_j       <= n_j;
        r_vi      <= n_vi;
        r_want    <= n_want;
        r_granted <= n_granted;
        r_status  <= n_status;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = {7'b0, r_status, r_granted};

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("request taken while a result is pending");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_status <= bba_pkg::ST_FULL))
        else $error("status code out of range");
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_status != bba_pkg::ST_OK) |-> (r_granted == '0))
        else $error("offset given with a failing status");
    a_top_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[NL-1] <= bba_pkg::f_cap(TopLvl))
        else $error("top list overfilled");
`endif
endmodule
`default_nettype wire
